### hdl/bounded_list_table_engine_assert.svh
// Assertion macros for the bounded list table engine.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_LIST_TABLE_ENGINE_ASSERT_SVH
`define BOUNDED_LIST_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BLTE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blte assertion failed");

// Next-cycle implication, disabled during reset.
`define BLTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blte assertion failed");

`endif

### hdl/blte_pkg.sv
// Shared types and codes for the bounded list table engine.
// No dependencies; used by blte_cell and bounded_list_table_engine.
`timescale 1ns / 1ps

package blte_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_APPEND     = 3'd1,
    OP_APPEND_UNQ = 3'd2,
    OP_DEL_FIRST  = 3'd3,
    OP_DEL_ALL    = 3'd4,
    OP_INSERT     = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  // What every cell does at the next edge.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_WRITE  = 2'd1,   // cell at the fill count takes the key
    CMD_DELETE = 2'd2,   // cells from the first match on take the right neighbor
    CMD_INSERT = 2'd3    // sorted insert: shift right from the insert point
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic signed [31:0] key;
  } cell_ctl_t;

  // Prefix flags rippling from cell 0 upward.
  typedef struct packed {
    logic eq;   // some lower valid cell equals the key
    logic ge;   // some lower valid cell is not less than the key
  } chain_t;

endpackage

### hdl/blte_cell.sv
// One list cell: holds one entry, compares it to the key, shifts with neighbors.
// Depends on blte_pkg.
`timescale 1ns / 1ps

module blte_cell import blte_pkg::*; #(
  parameter int CW  = 4,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [CW-1:0]       count,
  input  logic signed [31:0]  left_entry,
  input  logic signed [31:0]  right_entry,
  input  chain_t              chain_in,
  output chain_t              chain_out,
  output logic signed [31:0]  entry
);

  logic valid;
  logic at_end;
  logic eq;
  logic lt;

  assign valid  = CW'(IDX) < count;
  assign at_end = CW'(IDX) == count;
  assign eq     = valid && (entry == ctl.key);
  assign lt     = valid && (entry < ctl.key);

  assign chain_out.eq = chain_in.eq || eq;
  assign chain_out.ge = chain_in.ge || (valid && !lt);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_HOLD: begin
      end
      CMD_WRITE: begin
        if (at_end) entry <= ctl.key;
      end
      CMD_DELETE: begin
        if (chain_in.eq || eq) entry <= right_entry;
      end
      CMD_INSERT: begin
        if (chain_in.ge) begin
          entry <= left_entry;
        end else if ((valid && !lt) || at_end) begin
          entry <= ctl.key;
        end
      end
    endcase
  end

endmodule

### hdl/bounded_list_table_engine.sv
// Bounded list table engine: top level, FSM and a chain of DEPTH blte_cell.
// Depends on blte_pkg, blte_cell and bounded_list_table_engine_assert.svh.
// A request is taken only in S_IDLE and runs in S_EXEC; out_valid is registered when it ends.
// Delete-all removes one match per step; a held result stalls the finish, not those deletes.
// Reset (rst, synchronous): clears fill count, FSM and out_valid; entries are not cleared.
`timescale 1ns / 1ps
`include "bounded_list_table_engine_assert.svh"

module bounded_list_table_engine import blte_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] value,
  input  logic [2:0]         read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [3:0]         fill_count,
  output logic [3:0]         removed,
  output logic signed [31:0] read_value
);

  localparam int CW   = $clog2(DEPTH + 1);       // fill count width
  localparam int RD_N = (DEPTH < 8) ? DEPTH : 8; // entries reachable by read_index
  localparam int IW   = (CW > 3) ? CW : 3;       // common width for index compare

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // Request register, loaded on the input transfer.
  op_t                req_op;
  logic signed [31:0] req_value;
  logic [2:0]         req_idx;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rm_cnt, rm_cnt_next;   // delete-all tally

  cell_cmd_t          cmd;
  cell_ctl_t          ctl;
  chain_t             chain [DEPTH+1];
  logic signed [31:0] ent   [DEPTH];

  logic               full;
  logic               any_eq;
  logic               slot_free;
  logic               finish;
  status_t            st;
  logic [CW-1:0]      rm_out;
  logic signed [31:0] rd;
  logic               in_range;
  logic [CW+3:0]      cnt_ext;
  logic [CW+3:0]      rm_ext;

  // Chain of cells: prefix flags ripple upward, entries shift either way.
  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_e;
    logic signed [31:0] right_e;
    if (i == 0) begin : g_first
      assign left_e = ctl.key;
    end else begin : g_mid
      assign left_e = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = ent[i];
    end else begin : g_inner
      assign right_e = ent[i+1];
    end
    blte_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .left_entry  (left_e),
      .right_entry (right_e),
      .chain_in    (chain[i]),
      .chain_out   (chain[i+1]),
      .entry       (ent[i])
    );
  end

  assign full      = count >= CW'(DEPTH);
  assign any_eq    = chain[DEPTH].eq;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = state == S_IDLE;
  assign ctl       = '{cmd: cmd, key: req_value};
  assign in_range  = IW'(req_idx) < IW'(count);

  // Read port: small mux over the entries read_index can reach.
  always_comb begin
    rd = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (req_idx == 3'(k)) rd = ent[k];
    end
  end

  // Execute step: at most one chain command per cycle; delete-all repeats until no match.
  always_comb begin
    cmd         = CMD_HOLD;
    count_next  = count;
    rm_cnt_next = rm_cnt;
    finish      = 1'b0;
    st          = ST_DONE;
    rm_out      = '0;
    if (state == S_EXEC) begin
      unique case (req_op)
        OP_CLEAR: begin
          if (slot_free) begin
            count_next = '0;
            finish     = 1'b1;
          end
        end
        OP_APPEND: begin
          if (slot_free) begin
            finish = 1'b1;
            if (full) begin
              st = ST_FULL;
            end else begin
              cmd        = CMD_WRITE;
              count_next = count + CW'(1);
            end
          end
        end
        OP_APPEND_UNQ: begin
          if (slot_free) begin
            finish = 1'b1;
            if (full) begin
              st = ST_FULL;
            end else if (any_eq) begin
              st = ST_DUP;
            end else begin
              cmd        = CMD_WRITE;
              count_next = count + CW'(1);
            end
          end
        end
        OP_DEL_FIRST: begin
          if (slot_free) begin
            finish = 1'b1;
            if (any_eq) begin
              cmd        = CMD_DELETE;
              count_next = count - CW'(1);
              rm_out     = CW'(1);
            end else begin
              st = ST_NOTFOUND;
            end
          end
        end
        OP_DEL_ALL: begin
          if (any_eq) begin
            cmd         = CMD_DELETE;
            count_next  = count - CW'(1);
            rm_cnt_next = rm_cnt + CW'(1);
          end else if (slot_free) begin
            finish = 1'b1;
            rm_out = rm_cnt;
            st     = (rm_cnt == '0) ? ST_NOTFOUND : ST_DONE;
          end
        end
        OP_INSERT: begin
          if (slot_free) begin
            finish = 1'b1;
            if (full) begin
              st = ST_FULL;
            end else begin
              cmd        = CMD_INSERT;
              count_next = count + CW'(1);
            end
          end
        end
        OP_READ: begin
          if (slot_free) begin
            finish = 1'b1;
            if (!in_range) st = ST_RANGE;
          end
        end
        default: begin
          // unused opcode: no change, status done
          if (slot_free) finish = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Output counts are the low four bits of the internal counts.
  assign cnt_ext = {4'b0, count_next};
  assign rm_ext  = {4'b0, rm_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op    <= op_t'(opcode);
      req_value <= value;
      req_idx   <= read_index;
      rm_cnt    <= '0;
    end else begin
      rm_cnt <= rm_cnt_next;
    end
    if (finish) begin
      status     <= st;
      fill_count <= cnt_ext[3:0];
      removed    <= rm_ext[3:0];
      read_value <= (req_op == OP_READ && in_range) ? rd : 32'sd0;
    end
  end

  // Checks
  `BLTE_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `BLTE_ASSERT_IMPL(a_full_count, clk, rst, out_valid && status == ST_FULL,
                    fill_count == 4'(DEPTH))
  `BLTE_ASSERT_IMPL(a_removed_done, clk, rst, out_valid && removed != 4'd0,
                    status == ST_DONE)
  `BLTE_ASSERT_NEXT(a_del_step, clk, rst, state == S_EXEC && cmd == CMD_DELETE,
                    count == $past(count) - CW'(1))
  `BLTE_ASSERT_IMPL(a_exec_no_take, clk, rst, state == S_EXEC, !in_ready)

endmodule
